// ----- rtl/spwm_pkg.sv -----
// Shared types, constants and the sine table function of the three-phase sine PWM generator.
`timescale 1ns / 1ps

package spwm_pkg;

  localparam int PHASE_BITS_DEF     = 24;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int DUTY_BITS_DEF      = 10;

  // duty ports and duty bound registers are fixed at ten bits
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 2;
  // magnitude bits of a Q1.15 sine word
  localparam int SINE_W    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 2'd1;

  localparam logic [REG_W-1:0] DUTY_MIN_RST = 10'd51;
  localparam logic [REG_W-1:0] DUTY_MAX_RST = 10'd971;

  localparam logic [63:0] PI_Q30  = 64'hC90F_DAA2;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // which of the three phases a pipeline slot carries
  typedef enum logic [1:0] {
    SLOT_A,
    SLOT_B,
    SLOT_C
  } slot_t;

  typedef struct packed {
    logic  vld;
    slot_t slot;
    logic  neg;
  } tag_t;

  // Quarter-wave sine magnitude for first-quadrant index idx, evaluated at elaboration.
  // Taylor series to x^13 in Q2.30, Horner form, truncating shifts and divisions.
  function automatic logic [SINE_W-1:0] sine_mag(input int unsigned idx,
                                                 input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (PI_Q30 * 64'(idx)) >> (addr_bits - 1);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SINE_W-1:0];
  endfunction

endpackage

// ----- rtl/spwm_sine_rom.sv -----
// Quarter-wave sine ROM with registered read data.
`timescale 1ns / 1ps

module spwm_sine_rom #(
  parameter int ADDR_BITS = spwm_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ADDR_BITS-2:0]        idx,
  output logic [spwm_pkg::SINE_W-1:0] q
);

  // indices 0 .. quarter inclusive, so one entry past a power of two
  localparam int ROM_DEPTH = (1 << (ADDR_BITS - 2)) + 1;

  logic [spwm_pkg::SINE_W-1:0] rom_mem [ROM_DEPTH];
  logic [spwm_pkg::SINE_W-1:0] q_r;

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    localparam logic [spwm_pkg::SINE_W-1:0] WORD = spwm_pkg::sine_mag(i, ADDR_BITS);
    assign rom_mem[i] = WORD;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= rom_mem[idx];
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/spwm_duty.sv -----
// Sine word to duty count: offset, scale to full scale, register, then clamp to the bounds.
`timescale 1ns / 1ps

module spwm_duty #(
  parameter int DUTY_BITS = spwm_pkg::DUTY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  spwm_pkg::tag_t              tag_in,
  input  logic [spwm_pkg::SINE_W-1:0] mag,
  input  logic [spwm_pkg::REG_W-1:0]  duty_min,
  input  logic [spwm_pkg::REG_W-1:0]  duty_max,
  output spwm_pkg::tag_t              tag_out,
  output logic [spwm_pkg::REG_W-1:0]  duty
);

  localparam int PW = 16 + DUTY_BITS;
  localparam int CW = (DUTY_BITS > spwm_pkg::REG_W) ? DUTY_BITS : spwm_pkg::REG_W;
  localparam logic [DUTY_BITS-1:0] PWM_MAX_D = {DUTY_BITS{1'b1}};
  localparam logic [CW-1:0]        PWM_MAX_C = CW'(PWM_MAX_D);

  logic [15:0]          ofs;
  logic [PW-1:0]        prod;
  logic [DUTY_BITS-1:0] raw_r, raw_nxt;
  spwm_pkg::tag_t       tag_r, tag_nxt;
  logic [CW-1:0]        clip;

  // s + 1 in unsigned 16-bit: 0x8000 -/+ magnitude
  always_comb begin
    if (tag_in.neg) begin
      ofs = 16'h8000 - {1'b0, mag};
    end else begin
      ofs = 16'h8000 + {1'b0, mag};
    end
    prod = PW'(ofs) * PW'(PWM_MAX_D);
  end

  always_comb begin
    raw_nxt = raw_r;
    tag_nxt = tag_r;
    if (en) begin
      raw_nxt = prod[16 +: DUTY_BITS];
      tag_nxt = tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  // lower bound first, so the upper bound wins when they cross
  always_comb begin
    clip = CW'(raw_r);
    if (clip < CW'(duty_min)) begin
      clip = CW'(duty_min);
    end
    if (clip > CW'(duty_max)) begin
      clip = CW'(duty_max);
    end
    if (clip > PWM_MAX_C) begin
      clip = PWM_MAX_C;
    end
  end

  assign duty    = clip[spwm_pkg::REG_W-1:0];
  assign tag_out = tag_r;

endmodule

// ----- rtl/three_phase_sine_pwm_generator.sv -----
// An accepted item waits in the job register, and its phases pass in turn through the
// address, ROM and duty registers into the output register. The three phases share the
// one read port of the quarter-wave sine ROM, one read per cycle while not frozen.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low): phase accumulator to zero, duty bounds to 51 and 971,
// pipeline and output emptied.
`timescale 1ns / 1ps

module three_phase_sine_pwm_generator #(
  parameter int PHASE_BITS     = spwm_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = spwm_pkg::SINE_ADDR_BITS_DEF,
  parameter int DUTY_BITS      = spwm_pkg::DUTY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [PHASE_BITS-1:0]        in_phase_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spwm_pkg::REG_W-1:0]          out_duty_a,
  output logic [spwm_pkg::REG_W-1:0]          out_duty_b,
  output logic [spwm_pkg::REG_W-1:0]          out_duty_c,
  input  logic                                cfg_we,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spwm_pkg::REG_W-1:0]          cfg_wdata
);

  localparam logic [63:0] THIRD_FULL = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;
  localparam logic [PHASE_BITS-1:0] THIRD = THIRD_FULL[PHASE_BITS-1:0];
  localparam logic [SINE_ADDR_BITS-2:0] QUARTER = {1'b1, {(SINE_ADDR_BITS-2){1'b0}}};

  // configuration
  logic [spwm_pkg::REG_W-1:0] duty_min_r, duty_min_nxt;
  logic [spwm_pkg::REG_W-1:0] duty_max_r, duty_max_nxt;

  // accumulator and the item being issued
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] job_phase_r, job_phase_nxt;
  logic                  job_vld_r, job_vld_nxt;
  spwm_pkg::slot_t       job_slot_r, job_slot_nxt;

  // address stage
  logic [PHASE_BITS-1:0]     slot_phase;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-2:0] r_ofs;
  logic [SINE_ADDR_BITS-2:0] idx;
  logic [SINE_ADDR_BITS-2:0] s1_idx_r, s1_idx_nxt;
  spwm_pkg::tag_t            s1_tag_r, s1_tag_nxt;

  // ROM and duty stages
  spwm_pkg::tag_t              s2_tag_r, s2_tag_nxt;
  logic [spwm_pkg::SINE_W-1:0] rom_q;
  spwm_pkg::tag_t              s3_tag;
  logic [spwm_pkg::REG_W-1:0]  s3_duty;

  // result assembly and output register
  logic [spwm_pkg::REG_W-1:0] asm_a_r, asm_a_nxt;
  logic [spwm_pkg::REG_W-1:0] asm_b_r, asm_b_nxt;
  logic [spwm_pkg::REG_W-1:0] duty_a_r, duty_a_nxt;
  logic [spwm_pkg::REG_W-1:0] duty_b_r, duty_b_nxt;
  logic [spwm_pkg::REG_W-1:0] duty_c_r, duty_c_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic s3_last, adv, issue, issue_last, in_acc, complete;

  // the pipeline only freezes when a finished item has nowhere to go
  assign s3_last    = s3_tag.vld && (s3_tag.slot == spwm_pkg::SLOT_C);
  assign adv        = !(out_valid_r && out_stall && s3_last);
  assign issue      = adv && job_vld_r;
  assign issue_last = issue && (job_slot_r == spwm_pkg::SLOT_C);
  assign in_stall   = job_vld_r && !issue_last;
  assign in_acc     = in_valid && !in_stall;
  assign complete   = adv && s3_last;

  // ---- configuration writes
  always_comb begin
    duty_min_nxt = duty_min_r;
    duty_max_nxt = duty_max_r;
    if (cfg_we) begin
      unique case (cfg_index)
        spwm_pkg::REG_DUTY_MIN: duty_min_nxt = cfg_wdata;
        spwm_pkg::REG_DUTY_MAX: duty_max_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- accumulator and issue sequencing
  always_comb begin
    phase_acc_nxt = phase_acc_r;
    job_phase_nxt = job_phase_r;
    job_vld_nxt   = job_vld_r;
    job_slot_nxt  = job_slot_r;
    if (issue) begin
      case (job_slot_r)
        spwm_pkg::SLOT_A: job_slot_nxt = spwm_pkg::SLOT_B;
        spwm_pkg::SLOT_B: job_slot_nxt = spwm_pkg::SLOT_C;
        default:          job_slot_nxt = job_slot_r;
      endcase
    end
    if (issue_last) begin
      job_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      phase_acc_nxt = phase_acc_r + $unsigned(in_phase_step);
      job_phase_nxt = phase_acc_nxt;
      job_vld_nxt   = 1'b1;
      job_slot_nxt  = spwm_pkg::SLOT_A;
    end
  end

  // ---- phase of the slot being issued and its quarter-wave index
  always_comb begin
    case (job_slot_r)
      spwm_pkg::SLOT_B: slot_phase = job_phase_r + THIRD;
      spwm_pkg::SLOT_C: slot_phase = job_phase_r - THIRD;
      default:          slot_phase = job_phase_r;
    endcase
  end

  if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_trunc
    assign addr = slot_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  end else begin : g_addr_ext
    assign addr = {slot_phase, {(SINE_ADDR_BITS-PHASE_BITS){1'b0}}};
  end

  assign quad  = addr[SINE_ADDR_BITS-1 -: 2];
  assign r_ofs = {1'b0, addr[SINE_ADDR_BITS-3:0]};
  // odd quadrants run the table backwards
  assign idx   = quad[0] ? (QUARTER - r_ofs) : r_ofs;

  always_comb begin
    s1_idx_nxt = s1_idx_r;
    s1_tag_nxt = s1_tag_r;
    s2_tag_nxt = s2_tag_r;
    if (adv) begin
      s1_idx_nxt     = idx;
      s1_tag_nxt.vld  = issue;
      s1_tag_nxt.slot = job_slot_r;
      s1_tag_nxt.neg  = quad[1];
      s2_tag_nxt     = s1_tag_r;
    end
  end

  spwm_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk (clk),
    .en  (adv),
    .idx (s1_idx_r),
    .q   (rom_q)
  );

  spwm_duty #(
    .DUTY_BITS (DUTY_BITS)
  ) u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .tag_in   (s2_tag_r),
    .mag      (rom_q),
    .duty_min (duty_min_r),
    .duty_max (duty_max_r),
    .tag_out  (s3_tag),
    .duty     (s3_duty)
  );

  // ---- collect the three phases of an item
  always_comb begin
    asm_a_nxt     = asm_a_r;
    asm_b_nxt     = asm_b_r;
    duty_a_nxt    = duty_a_r;
    duty_b_nxt    = duty_b_r;
    duty_c_nxt    = duty_c_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (adv && s3_tag.vld) begin
      case (s3_tag.slot)
        spwm_pkg::SLOT_A: asm_a_nxt = s3_duty;
        spwm_pkg::SLOT_B: asm_b_nxt = s3_duty;
        default: begin
          duty_a_nxt    = asm_a_r;
          duty_b_nxt    = asm_b_r;
          duty_c_nxt    = s3_duty;
          out_valid_nxt = 1'b1;
        end
      endcase
    end
    if (complete) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_min_r  <= spwm_pkg::DUTY_MIN_RST;
      duty_max_r  <= spwm_pkg::DUTY_MAX_RST;
      phase_acc_r <= '0;
      job_vld_r   <= 1'b0;
      job_slot_r  <= spwm_pkg::SLOT_A;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      duty_min_r  <= duty_min_nxt;
      duty_max_r  <= duty_max_nxt;
      phase_acc_r <= phase_acc_nxt;
      job_vld_r   <= job_vld_nxt;
      job_slot_r  <= job_slot_nxt;
      s1_tag_r    <= s1_tag_nxt;
      s2_tag_r    <= s2_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_phase_r <= job_phase_nxt;
    s1_idx_r    <= s1_idx_nxt;
    asm_a_r     <= asm_a_nxt;
    asm_b_r     <= asm_b_nxt;
    duty_a_r    <= duty_a_nxt;
    duty_b_r    <= duty_b_nxt;
    duty_c_r    <= duty_c_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_duty_a = duty_a_r;
  assign out_duty_b = duty_b_r;
  assign out_duty_c = duty_c_r;

endmodule

// ----- rtl/spwm_checker.sv -----
// Port-level checks on the three-phase sine PWM generator, bound to the top level.
`timescale 1ns / 1ps

module spwm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [spwm_pkg::REG_W-1:0] out_duty_a,
  input logic [spwm_pkg::REG_W-1:0] out_duty_b,
  input logic [spwm_pkg::REG_W-1:0] out_duty_c
);

  // items accepted whose result has not yet been taken
  logic [3:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 4'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_a) && $stable(out_duty_b)
                               && $stable(out_duty_c))
    else $error("stalled result dropped or changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result with no item outstanding");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'd0 |=> !out_valid)
    else $error("result one cycle after an empty block");

endmodule

bind three_phase_sine_pwm_generator spwm_checker u_spwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_duty_a (out_duty_a),
  .out_duty_b (out_duty_b),
  .out_duty_c (out_duty_c)
);

// ----- tb/sv/spwm_duty_checker.sv -----
// Scoreboard for the three-phase sine PWM generator: predicts each duty item and checks it.
`timescale 1ns / 1ps

module spwm_duty_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [spwm_pkg::PHASE_BITS_DEF-1:0] in_phase_step,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [spwm_pkg::REG_W-1:0]          out_duty_a,
  input  logic [spwm_pkg::REG_W-1:0]          out_duty_b,
  input  logic [spwm_pkg::REG_W-1:0]          out_duty_c,
  input  logic                                cfg_we,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spwm_pkg::REG_W-1:0]          cfg_wdata,
  output int                                  errors,
  output int                                  n_pending
);
  import spwm_pkg::*;

  localparam int PHASE_W   = PHASE_BITS_DEF;
  localparam int ADDR_W    = SINE_ADDR_BITS_DEF;
  localparam int QUARTER   = 1 << (ADDR_W - 2);
  localparam int DUTY_FULL = (1 << DUTY_BITS_DEF) - 1;
  localparam logic [PHASE_W-1:0] THIRD_TURN = PHASE_W'(((1 << PHASE_W) + 1) / 3);

  // index 0 is phase A, 1 is B, 2 is C
  typedef logic [2:0][REG_W-1:0] duty_set_t;

  logic signed [16:0]  sine_word [1 << ADDR_W];
  logic [PHASE_W-1:0]  phase;
  logic [REG_W-1:0]    lo_bound;
  logic [REG_W-1:0]    hi_bound;
  duty_set_t           queued_duties [$];

  // Q15 magnitude of sin(idx * pi / 2 / QUARTER): Taylor series to x^13 in Q2.30
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned idx);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] acc;
    logic [63:0] scaled;
    int          n;
    ang    = (PI_Q30 * 64'(idx)) >> (ADDR_W - 1);
    ang_sq = (ang * ang) >> 30;
    acc    = ONE_Q30;
    // innermost term first: divisors 12*13 down to 2*3
    for (n = 6; n >= 1; n--) begin
      acc = ONE_Q30 - ((ang_sq * acc) >> 30) / 64'(2 * n * (2 * n + 1));
    end
    scaled = (((ang * acc) >> 30) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (scaled > 64'd32767) begin
      scaled = 64'd32767;
    end
    return scaled[SINE_W-1:0];
  endfunction

  function automatic logic [REG_W-1:0] duty_for(input logic [PHASE_W-1:0] ph);
    int d;
    d = ((int'(sine_word[ph[PHASE_W-1 -: ADDR_W]]) + 32768) * DUTY_FULL) >>> 16;
    // lower bound first, so the upper one wins when they cross
    if (d < int'(lo_bound)) begin
      d = int'(lo_bound);
    end
    if (d > int'(hi_bound)) begin
      d = int'(hi_bound);
    end
    if (d > DUTY_FULL) begin
      d = DUTY_FULL;
    end
    return REG_W'(d);
  endfunction

  initial begin
    int quad;
    int r;
    int idx;
    int mag;
    for (int addr = 0; addr < (1 << ADDR_W); addr++) begin
      quad = addr / QUARTER;
      r    = addr % QUARTER;
      idx  = (quad % 2 == 1) ? QUARTER - r : r;
      mag  = int'(quarter_sine(idx));
      sine_word[addr] = (quad >= 2) ? 17'(-mag) : 17'(mag);
    end
  end

  always @(posedge clk) begin
    duty_set_t want;
    duty_set_t got;
    if (!rst_n) begin
      phase    = '0;
      lo_bound = DUTY_MIN_RST;
      hi_bound = DUTY_MAX_RST;
      queued_duties.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DUTY_MIN: lo_bound = cfg_wdata;
          REG_DUTY_MAX: hi_bound = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        phase   = phase + in_phase_step;
        want[0] = duty_for(phase);
        want[1] = duty_for(phase + THIRD_TURN);
        want[2] = duty_for(phase - THIRD_TURN);
        queued_duties.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_duty_c, out_duty_b, out_duty_a};
        if (queued_duties.size() == 0) begin
          errors++;
          $display("%0t: unexpected item a=%0d b=%0d c=%0d, expected none", $time,
                   out_duty_a, out_duty_b, out_duty_c);
        end else begin
          want = queued_duties.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== want[i]) begin
              errors++;
              $display("%0t: duty_%c expected %0d, got %0d", $time, 8'(97 + i),
                       want[i], got[i]);
            end
          end
        end
      end
    end
    n_pending = queued_duties.size();
  end

endmodule

// ----- tb/sv/three_phase_sine_pwm_generator_tb.sv -----
// Top of the three-phase sine PWM generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module three_phase_sine_pwm_generator_tb;
  import spwm_pkg::*;

  localparam int STEP_W      = PHASE_BITS_DEF;
  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 57;
  localparam logic [STEP_W-1:0] THIRD_TURN = STEP_W'(5592405);
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [STEP_W-1:0]    in_phase_step;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [REG_W-1:0]     out_duty_a;
  logic [REG_W-1:0]     out_duty_b;
  logic [REG_W-1:0]     out_duty_c;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  int   errors;
  int   n_pending;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  bit   burst = 1'b0;
  bit   hold_rx = 1'b0;

  logic [REG_W-1:0] lo_set [7] = '{10'd0, 10'd1023, 10'd600, 10'd300, 10'd51, 10'd1023, 10'd0};
  logic [REG_W-1:0] hi_set [7] = '{10'd1023, 10'd0, 10'd400, 10'd700, 10'd971, 10'd1023, 10'd0};

  three_phase_sine_pwm_generator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_phase_step (in_phase_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_duty_a    (out_duty_a),
    .out_duty_b    (out_duty_b),
    .out_duty_c    (out_duty_c),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  spwm_duty_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_phase_step (in_phase_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_duty_a    (out_duty_a),
    .out_duty_b    (out_duty_b),
    .out_duty_c    (out_duty_c),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .n_pending     (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("** three_phase_sine_pwm_generator: FAILED **");
      $finish;
    end
  end

  // an even mix of wild steps, slow sweeps, near quarter turns and turn fractions
  function automatic logic [STEP_W-1:0] random_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(0, 3))
      0: s = STEP_W'($urandom());
      1: s = STEP_W'($urandom_range(0, 1 << 18)) - STEP_W'(1 << 17);
      2: s = STEP_W'($urandom_range(0, 3)) << (STEP_W - 2) ^ STEP_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = THIRD_TURN;
          default: s = -THIRD_TURN;
        endcase
      end
    endcase
    return s;
  endfunction

  // entered and left just after a falling edge
  task automatic send_step(input logic [STEP_W-1:0] step);
    int gap;
    gap = (burst || no_idle) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_phase_step <= step;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_bounds(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DUTY_MIN;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= REG_DUTY_MAX;
    cfg_wdata <= hi;
    @(negedge clk);
    // a write to an unused index must leave both bounds alone
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_wdata <= REG_W'($urandom());
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random stall before each item, one long hold-off on request
  initial begin
    int wait_cycles;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_rx && !hold_done) begin
        hold_done   = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    in_valid      <= 1'b0;
    in_phase_step <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_DUTY_MIN;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners at the reset bounds: no step, smallest, widest both ways, turn fractions
    send_step(24'h000000);
    send_step(24'h000001);
    send_step(24'hFFFFFF);
    send_step(24'h7FFFFF);
    send_step(24'h800000);
    send_step(THIRD_TURN);
    send_step(-THIRD_TURN);
    send_step(24'h400000);
    send_step(24'h004000);
    send_step(24'h003FFF);
    send_step(24'h555555);
    send_step(24'hAAAAAA);
    send_step(24'hC00000);
    send_step(24'h400000);

    for (int p = 0; p < 7; p++) begin
      drain_results();
      program_bounds(lo_set[p], hi_set[p]);
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 10) begin
          hold_rx = 1'b1;
          burst   = 1'b1;
        end
        if (p == 3 && n == 30) begin
          burst = 1'b0;
        end
        if (p == 4 && n == 28) begin
          drain_results();
        end
        send_step(random_step());
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("** three_phase_sine_pwm_generator: PASSED **");
    end else begin
      $display("** three_phase_sine_pwm_generator: FAILED **");
    end
    $finish;
  end

endmodule
